[rtl/core/tga_rle_pkg.sv]
// shared types and constants for the tga run-length line encoder
`default_nettype none

package tga_rle_pkg;

    // literal store geometry: words held four to a row
    localparam int STORE_DEPTH = 128;
    localparam int LANES       = 4;
    localparam int ROWS        = STORE_DEPTH / LANES;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int LANE_W      = $clog2(LANES);
    localparam int PIX_W       = 32;
    localparam int CNT_W       = 8;
    localparam int WC_W        = 3;

    // packet header codes
    localparam logic [7:0] RUN_FLAG = 8'h80;

    // one result transaction before the output register
    typedef struct packed {
        logic                        has_header;
        logic [7:0]                  header_byte;
        logic [WC_W-1:0]             word_count;
        logic [LANES-1:0][PIX_W-1:0] words;
    } t_result;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cap_in;
        logic load_new;
        logic inc_run;
        logic clr_held;
        logic lit_push;
        logic rd_row;
        logic emit_raw;
        logic emit_run;
        logic finish;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_last;
        logic match;
        logic held_valid;
        logic run_ge2;
        logic lit_nonzero;
        logic lit_full_next;
        logic flush_last;
        logic can_emit;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/core/tga_rle_ctrl.sv]
// sequencing controller for the tga run-length line encoder
`default_nettype none

module tga_rle_ctrl import tga_rle_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_CLOSE  = 8'b0000_0100,
        S_ENDC   = 8'b0000_1000,
        S_FRD    = 8'b0001_0000,
        S_FEMIT  = 8'b0010_0000,
        S_RUN    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    // which close or flush of the current pixel is under way
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LAST  = 2'd1,
        PH_FINAL = 2'd2
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_ret_run, n_ret_run;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_FIRST;
            r_ret_run <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_ret_run <= n_ret_run;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_ret_run = r_ret_run;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.match || !i_status.held_valid) begin
                    o_cmd.inc_run  = i_status.match;
                    o_cmd.load_new = !i_status.match;
                    if (i_status.in_last) begin
                        n_phase = PH_LAST;
                        n_state = S_CLOSE;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_phase = PH_FIRST;
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (i_status.run_ge2) begin
                    if (i_status.lit_nonzero) begin
                        n_ret_run = 1'b1;
                        n_state   = S_FRD;
                    end else begin
                        n_state = S_RUN;
                    end
                end else begin
                    o_cmd.lit_push = 1'b1;
                    if (i_status.lit_full_next) begin
                        n_ret_run = 1'b0;
                        n_state   = S_FRD;
                    end else begin
                        n_state = S_ENDC;
                    end
                end
            end
            S_ENDC: begin
                if (r_phase == PH_FIRST) begin
                    o_cmd.load_new = 1'b1;
                    if (i_status.in_last) begin
                        n_phase = PH_LAST;
                        n_state = S_CLOSE;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.clr_held = 1'b1;
                    if (i_status.lit_nonzero) begin
                        n_phase   = PH_FINAL;
                        n_ret_run = 1'b0;
                        n_state   = S_FRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FRD: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_FEMIT;
            end
            S_FEMIT: begin
                if (i_status.can_emit) begin
                    o_cmd.emit_raw = 1'b1;
                    if (!i_status.flush_last) begin
                        n_state = S_FRD;
                    end else if (r_phase == PH_FINAL) begin
                        n_state = S_FIN;
                    end else if (r_ret_run) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_ENDC;
                    end
                end
            end
            S_RUN: begin
                if (i_status.can_emit) begin
                    o_cmd.emit_run = 1'b1;
                    n_state        = S_ENDC;
                end
            end
            S_FIN: begin
                if (i_status.can_emit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/tga_rle_dpath.sv]
// run state, literal store and result registers of the tga run-length encoder
`default_nettype none

module tga_rle_dpath import tga_rle_pkg::*; #(
    parameter int MAX_PACKET = 128
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [PIX_W-1:0]  i_pixel,
    input  wire               i_line_end,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output t_result           o_out,
    output logic              o_out_last
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET);

    // captured input transaction
    logic [PIX_W-1:0] r_in_px;
    logic             r_in_last;

    // open run
    logic [PIX_W-1:0] r_held;
    logic             r_held_v;
    logic [CNT_W-1:0] r_run;

    // literal store, read one row at a time
    logic [LANES-1:0][PIX_W-1:0] r_mem [ROWS];
    logic [LANES-1:0][PIX_W-1:0] r_rd_row;
    logic [CNT_W-1:0]            r_lit_cnt;
    logic [ROW_W-1:0]            r_fpos;

    // pending result and output register
    t_result r_pend;
    logic    r_pend_v;
    t_result r_out;
    logic    r_out_v;
    logic    r_out_last;

    logic             out_free;
    logic [CNT_W-1:0] remain;
    logic [WC_W-1:0]  take;
    logic             flush_last;
    logic [CNT_W:0]   cnt_inc;
    t_result          raw_res;
    t_result          run_res;
    t_result          new_res;
    logic             produce;

    assign out_free = !r_out_v || i_out_ready;
    assign remain   = r_lit_cnt - {1'b0, r_fpos, {LANE_W{1'b0}}};
    assign flush_last = (remain <= CNT_W'(LANES));
    assign take     = flush_last ? remain[WC_W-1:0] : WC_W'(LANES);
    assign cnt_inc  = {1'b0, r_lit_cnt} + 1'b1;

    // status to the controller
    always_comb begin
        o_status.in_last       = r_in_last;
        o_status.match         = r_held_v && (r_run < MAX_CNT) && (r_in_px == r_held);
        o_status.held_valid    = r_held_v;
        o_status.run_ge2       = (r_run >= CNT_W'(2));
        o_status.lit_nonzero   = (r_lit_cnt != '0);
        o_status.lit_full_next = (cnt_inc >= (CNT_W+1)'(MAX_PACKET));
        o_status.flush_last    = flush_last;
        o_status.can_emit      = !r_pend_v || out_free;
    end

    // raw packet chunk, words past the count forced to zero
    always_comb begin
        logic [CNT_W-1:0] nm1;
        nm1 = r_lit_cnt - 1'b1;
        raw_res.has_header  = (r_fpos == '0);
        raw_res.header_byte = (r_fpos == '0) ? {1'b0, nm1[6:0]} : 8'h00;
        raw_res.word_count  = take;
        for (int k = 0; k < LANES; k++) begin
            raw_res.words[k] = (WC_W'(k) < take) ? r_rd_row[k] : '0;
        end
    end

    // run packet
    always_comb begin
        logic [CNT_W-1:0] rm1;
        rm1 = r_run - 1'b1;
        run_res.has_header  = 1'b1;
        run_res.header_byte = RUN_FLAG | {1'b0, rm1[6:0]};
        run_res.word_count  = WC_W'(1);
        run_res.words       = '0;
        run_res.words[0]    = r_held;
    end

    assign produce = i_cmd.emit_raw || i_cmd.emit_run;
    assign new_res = i_cmd.emit_raw ? raw_res : run_res;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_in_px   <= i_pixel;
            r_in_last <= i_line_end;
        end
    end

    // open run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_run    <= '0;
        end else if (i_cmd.load_new) begin
            r_held   <= r_in_px;
            r_held_v <= 1'b1;
            r_run    <= CNT_W'(1);
        end else if (i_cmd.inc_run) begin
            r_run <= r_run + 1'b1;
        end else if (i_cmd.clr_held) begin
            r_held_v <= 1'b0;
            r_run    <= '0;
        end
    end

    // literal store write and row read
    always_ff @(posedge i_clk) begin
        if (i_cmd.lit_push) begin
            r_mem[r_lit_cnt[LANE_W+ROW_W-1:LANE_W]][r_lit_cnt[LANE_W-1:0]] <= r_held;
        end
        if (i_cmd.rd_row) begin
            r_rd_row <= r_mem[r_fpos];
        end
    end

    // literal count and flush position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit_cnt <= '0;
            r_fpos    <= '0;
        end else if (i_cmd.lit_push) begin
            r_lit_cnt <= cnt_inc[CNT_W-1:0];
        end else if (i_cmd.emit_raw) begin
            if (flush_last) begin
                r_lit_cnt <= '0;
                r_fpos    <= '0;
            end else begin
                r_fpos <= r_fpos + 1'b1;
            end
        end
    end

    // pending slot holds back each result until the next one shows whether it is final
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (produce) begin
                r_pend   <= new_res;
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if ((produce || i_cmd.finish) && r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= i_cmd.finish;
                r_out_v    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    assign o_out_last  = r_out_last;

    // a literal is only stored while the buffer has room
    a_lit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lit_push |-> (r_lit_cnt < MAX_CNT))
        else $error("literal pushed into a full buffer");

    // a raw chunk is only read out of a non-empty buffer
    a_raw_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_raw |-> (r_lit_cnt != '0))
        else $error("raw packet emitted from an empty buffer");

    // a closed run has no length
    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_v |-> (r_run == '0))
        else $error("run length left over after close");

    // the final result of an item leaves the pending slot empty
    a_finish_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && out_free) |=> !r_pend_v)
        else $error("pending result left after item finished");

endmodule

`default_nettype wire

[rtl/core/tga_rle_line_encoder.sv]
// top level of the tga run-length line encoder for 32-bit pixels
// sequencing: a pixel that causes no result passes through the capture, decide and finish states;
// each raw chunk of up to four words adds a row read and an emit (one-row read port of the literal
// store), each run packet an emit, each run close the close and end-of-close states
// one item in flight at a time: a new pixel is taken only once the last one has finished
// reset: synchronous active-low i_rst_n empties the open run, literal count and outputs
`default_nettype none

module tga_rle_line_encoder import tga_rle_pkg::*; #(
    parameter int MAX_PACKET = 128
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side: tdata = pixel[31:0]; tlast = line_end
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [31:0]  i_s_tdata,
    input  wire          i_s_tlast,
    // master side: tdata = header_byte[7:0], word_count[10:8], word0[42:11],
    // word1[74:43], word2[106:75], word3[138:107], zero pad[143:139]
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [143:0] o_m_tdata,
    // tuser = has_header[0]
    output logic [0:0]   o_m_tuser,
    // tlast = last_of_input
    output logic         o_m_tlast
);

    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    res;

    tga_rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tga_rle_dpath #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (i_s_tdata),
        .i_line_end  (i_s_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out       (res),
        .o_out_last  (o_m_tlast)
    );

    // pack the result transaction
    assign o_m_tdata = {5'b0, res.words[3], res.words[2], res.words[1], res.words[0],
                        res.word_count, res.header_byte};
    assign o_m_tuser = res.has_header;

endmodule

`default_nettype wire
